[rtl/core/report_packet_reassembler_crc_check_assert.svh]
// assertion macros for the report packet reassembler
// used by report_packet_reassembler_crc_check.sv, no other dependencies
`ifndef REPORT_PACKET_REASSEMBLER_CRC_CHECK_ASSERT_SVH
`define REPORT_PACKET_REASSEMBLER_CRC_CHECK_ASSERT_SVH

// same-cycle implication
`define RPR_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/rpr_pkg.sv]
// shared types, constants and crc function of the report packet reassembler
// no dependencies
package rpr_pkg;

   localparam int REPORT_BYTES = 20;
   localparam int ADDR_W       = $clog2(REPORT_BYTES);
   localparam int FILL_W       = $clog2(REPORT_BYTES + 2);

   localparam logic [15:0] CRC_POLY      = 16'h8005;
   localparam int          START_BIT     = 7;
   localparam int          CRC_FLAG_BIT  = 4;
   localparam logic [9:0]  MIN_PKT_LEN   = 10'd3;
   localparam logic [9:0]  MIN_CRC_LEN   = 10'd5;
   localparam logic [9:0]  CRC_TRAILER   = 10'd2;
   localparam int          MIN_START_RPT = 4;

   typedef enum logic {
      KIND_DATA,
      KIND_STATUS
   } kind_type;

   typedef enum logic [1:0] {
      VERDICT_OK,
      VERDICT_CRC_BAD,
      VERDICT_SHORT,
      VERDICT_ABORT
   } verdict_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      verdict_type verdict;
      logic [1:0]  message_type;
      logic [7:0]  command_code;
      logic [9:0]  data_count;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_WALK,
      ST_END,
      ST_FLUSH
   } state_type;

   // crc-16/buypass, msb first, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] x;
      x = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (x[15]) begin
            x = {x[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            x = {x[14:0], 1'b0};
         end
      end
      return x;
   endfunction

endpackage

[rtl/core/rpr_req_if.sv]
// request channel of the report packet reassembler: one report byte per transaction
// no dependencies
interface rpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       report_first;
   logic       report_last;

   modport source (output valid, rx_byte, report_first, report_last, input ready);
   modport sink (input valid, rx_byte, report_first, report_last, output ready);
endinterface

[rtl/core/rpr_rsp_if.sv]
// response channel of the report packet reassembler: data bytes and packet status
// no dependencies
interface rpr_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] payload_byte;
   logic [1:0] verdict;
   logic [1:0] message_type;
   logic [7:0] command_code;
   logic [9:0] data_count;
   logic       last_result;

   modport source (output valid, result_kind, payload_byte, verdict, message_type,
                   command_code, data_count, last_result, input ready);
   modport sink (input valid, result_kind, payload_byte, verdict, message_type,
                 command_code, data_count, last_result, output ready);
endinterface

[rtl/core/report_packet_reassembler_crc_check.sv]
// report packet reassembler with crc-16/buypass check, top level
// depends on rpr_pkg, rpr_req_if, rpr_rsp_if and the assertion macro header
`include "report_packet_reassembler_crc_check_assert.svh"

// usage
//  req carries report bytes, one per transaction, with report_first on the
//  header byte and report_last on the final byte of a report
//  rsp carries results: payload data bytes and one status per finished or
//  dropped packet; last_result marks the final result caused by a byte
//  a byte that does not end a report keeps req.ready high and gives no result
//  a report end starts a sequencer that walks the buffered report out of the
//  report memory, one byte per cycle unless rsp stalls, through its single
//  read port (two more reads for a start report)
//  req.ready is low while the sequencer runs
//  one result is held back until the next one or the report end is known, so
//  last_result can be set; rsp is driven from a register
//  when rsp stalls the sequencer waits on the held result, nothing is lost
//  reset (synchronous, active high) closes any packet and clears the report
//  fill count; the report memory is not cleared

module report_packet_reassembler_crc_check (
   input logic         clock,
   input logic         reset,
   rpr_req_if.sink     req,
   rpr_rsp_if.source   rsp
);
   import rpr_pkg::*;

   // report memory, one write and one read port
   logic [7:0]        store_mem [REPORT_BYTES];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ADDR_W-1:0] mem_raddr;
   logic [7:0]        mem_rdata_ff;

   // sequencer and packet state
   state_type         state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] len_ff, len_in;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic              open_ff, open_in;
   logic [9:0]        exp_len_ff, exp_len_in;
   logic [9:0]        taken_ff, taken_in;
   logic [1:0]        next_cnt_ff, next_cnt_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        pkt_hdr_ff, pkt_hdr_in;
   logic [7:0]        pkt_cmd_ff, pkt_cmd_in;
   logic [7:0]        crc_lo_ff, crc_lo_in;
   logic [7:0]        crc_hi_ff, crc_hi_in;
   logic [7:0]        rep_hdr_ff, rep_hdr_in;
   logic              crc_req_ff, crc_req_in;

   // held result and output register
   logic              pend_valid_ff, pend_valid_in;
   result_type        pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   // helpers
   logic              accept;
   logic [FILL_W-1:0] fill_base, fill_next;
   logic              out_free, can_emit;
   logic [7:0]        rd_byte;
   logic [7:0]        walk_hdr;
   logic              walk_crc, walk_done, walk_data;
   logic [9:0]        walk_end;
   logic [10:0]       taken_p2;
   logic              cur_crc;
   logic [9:0]        cur_end, upto;
   result_type        abort_res, end_res, data_res, emit_data;
   logic              emit_valid;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign rd_byte   = mem_rdata_ff;

   // buffer position of the incoming byte, saturating past the report size
   assign fill_base = req.report_first ? '0 : fill_ff;
   assign fill_next = (fill_base < FILL_W'(REPORT_BYTES)) ? fill_base + FILL_W'(1)
                                                          : FILL_W'(REPORT_BYTES + 1);
   assign mem_we    = accept && (fill_base < FILL_W'(REPORT_BYTES));
   assign mem_waddr = fill_base[ADDR_W-1:0];
   assign mem_raddr = (idx_in < FILL_W'(REPORT_BYTES)) ? idx_in[ADDR_W-1:0] : '0;

   // read data always belongs to idx_ff; a write to the same entry is forwarded
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= req.rx_byte;
      end
      if (mem_we && (mem_waddr == mem_raddr)) begin
         mem_rdata_ff <= req.rx_byte;
      end else begin
         mem_rdata_ff <= store_mem[mem_raddr];
      end
   end

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign can_emit = !pend_valid_ff || out_free;

   // per-byte decode of the walk; the header byte itself switches the crc flag
   assign walk_hdr  = (taken_ff == 10'd0) ? rd_byte : pkt_hdr_ff;
   assign walk_crc  = walk_hdr[CRC_FLAG_BIT];
   assign walk_end  = (walk_crc && exp_len_ff >= CRC_TRAILER) ? exp_len_ff - CRC_TRAILER
                                                              : exp_len_ff;
   assign taken_p2  = {1'b0, taken_ff} + {1'b0, CRC_TRAILER};
   assign walk_done = (idx_ff >= len_ff) || (taken_ff >= exp_len_ff);
   assign walk_data = (taken_ff >= MIN_PKT_LEN) && (taken_ff < walk_end);

   // data end of the packet as it stands
   assign cur_crc = pkt_hdr_ff[CRC_FLAG_BIT];
   assign cur_end = (cur_crc && exp_len_ff >= CRC_TRAILER) ? exp_len_ff - CRC_TRAILER
                                                           : exp_len_ff;
   assign upto    = (taken_ff < cur_end) ? taken_ff : cur_end;

   always_comb begin
      abort_res.kind         = KIND_STATUS;
      abort_res.payload_byte = 8'h00;
      abort_res.verdict      = VERDICT_ABORT;
      abort_res.message_type = pkt_hdr_ff[6:5];
      abort_res.command_code = pkt_cmd_ff;
      abort_res.data_count   = (upto >= MIN_PKT_LEN) ? upto - MIN_PKT_LEN : 10'd0;

      end_res.kind         = KIND_STATUS;
      end_res.payload_byte = 8'h00;
      if (exp_len_ff < MIN_PKT_LEN) begin
         end_res.verdict      = VERDICT_SHORT;
         end_res.message_type = 2'd0;
         end_res.command_code = 8'h00;
         end_res.data_count   = 10'd0;
      end else begin
         end_res.verdict      = (cur_crc && (crc_ff != {crc_hi_ff, crc_lo_ff})) ?
                                VERDICT_CRC_BAD : VERDICT_OK;
         end_res.message_type = pkt_hdr_ff[6:5];
         end_res.command_code = pkt_cmd_ff;
         end_res.data_count   = cur_end - MIN_PKT_LEN;
      end

      data_res.kind         = KIND_DATA;
      data_res.payload_byte = rd_byte;
      data_res.verdict      = VERDICT_OK;
      data_res.message_type = 2'd0;
      data_res.command_code = 8'h00;
      data_res.data_count   = 10'd0;
   end

   // sequencer: next state, state updates and result hand-off
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      open_in       = open_ff;
      exp_len_in    = exp_len_ff;
      taken_in      = taken_ff;
      next_cnt_in   = next_cnt_ff;
      crc_in        = crc_ff;
      pkt_hdr_in    = pkt_hdr_ff;
      pkt_cmd_in    = pkt_cmd_ff;
      crc_lo_in     = crc_lo_ff;
      crc_hi_in     = crc_hi_ff;
      rep_hdr_in    = rep_hdr_ff;
      crc_req_in    = crc_req_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      emit_valid    = 1'b0;
      emit_data     = data_res;

      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept) begin
               if (req.report_last) begin
                  fill_in = '0;
                  // oversized reports are dropped whole
                  if (fill_next <= FILL_W'(REPORT_BYTES)) begin
                     len_in   = fill_next;
                     state_in = ST_HDR;
                  end
               end else begin
                  fill_in = fill_next;
               end
            end
         end

         ST_HDR: begin
            rep_hdr_in = rd_byte;
            crc_hi_in  = 8'h00;
            if (rd_byte[START_BIT]) begin
               if (!(open_ff && !can_emit)) begin
                  if (open_ff) begin
                     emit_valid = 1'b1;
                     emit_data  = abort_res;
                  end
                  open_in    = 1'b0;
                  taken_in   = 10'd0;
                  exp_len_in = 10'd0;
                  crc_in     = 16'h0000;
                  if (len_ff < FILL_W'(MIN_START_RPT)) begin
                     state_in = ST_FLUSH;
                  end else begin
                     idx_in   = FILL_W'(1);
                     state_in = ST_LEN_HI;
                  end
               end
            end else if (!open_ff) begin
               state_in = ST_FLUSH;
            end else if (next_cnt_ff != rd_byte[1:0]) begin
               // counter mismatch drops the open packet
               if (can_emit) begin
                  emit_valid = 1'b1;
                  emit_data  = abort_res;
                  open_in    = 1'b0;
                  taken_in   = 10'd0;
                  state_in   = ST_FLUSH;
               end
            end else begin
               next_cnt_in = rd_byte[1:0] + 2'd1;
               idx_in      = FILL_W'(1);
               state_in    = ST_WALK;
            end
         end

         ST_LEN_HI: begin
            exp_len_in[9:8] = rd_byte[1:0];
            crc_req_in      = rd_byte[CRC_FLAG_BIT];
            idx_in          = FILL_W'(2);
            state_in        = ST_LEN_LO;
         end

         ST_LEN_LO: begin
            exp_len_in[7:0] = rd_byte;
            if (crc_req_ff && ({exp_len_ff[9:8], rd_byte} < MIN_CRC_LEN)) begin
               state_in = ST_FLUSH;
            end else begin
               next_cnt_in = rep_hdr_ff[1:0] + 2'd1;
               idx_in      = FILL_W'(1);
               state_in    = ST_WALK;
            end
         end

         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_END;
            end else if (!(walk_data && !can_emit)) begin
               if (taken_ff == 10'd0) begin
                  pkt_hdr_in = rd_byte;
               end
               if (taken_ff == 10'd2) begin
                  pkt_cmd_in = rd_byte;
               end
               if (walk_crc) begin
                  if (taken_p2 < {1'b0, exp_len_ff}) begin
                     crc_in = crc16_byte(crc_ff, rd_byte);
                  end else if (taken_p2 == {1'b0, exp_len_ff}) begin
                     crc_lo_in = rd_byte;
                  end else begin
                     crc_hi_in = rd_byte;
                  end
               end
               if (walk_data) begin
                  emit_valid = 1'b1;
                  emit_data  = data_res;
               end
               taken_in = taken_ff + 10'd1;
               idx_in   = idx_ff + FILL_W'(1);
            end
         end

         ST_END: begin
            if (taken_ff >= exp_len_ff) begin
               if (can_emit) begin
                  emit_valid = 1'b1;
                  emit_data  = end_res;
                  open_in    = 1'b0;
                  taken_in   = 10'd0;
                  state_in   = ST_FLUSH;
               end
            end else begin
               open_in  = 1'b1;
               state_in = ST_FLUSH;
            end
         end

         ST_FLUSH: begin
            // the held result is the last one of this transaction
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = pend_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a new result pushes the held one out
      if (emit_valid) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = pend_ff;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         len_ff        <= '0;
         idx_ff        <= '0;
         open_ff       <= 1'b0;
         exp_len_ff    <= 10'd0;
         taken_ff      <= 10'd0;
         next_cnt_ff   <= 2'd0;
         crc_ff        <= 16'h0000;
         pkt_hdr_ff    <= 8'h00;
         pkt_cmd_ff    <= 8'h00;
         crc_lo_ff     <= 8'h00;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         len_ff        <= len_in;
         idx_ff        <= idx_in;
         open_ff       <= open_in;
         exp_len_ff    <= exp_len_in;
         taken_ff      <= taken_in;
         next_cnt_ff   <= next_cnt_in;
         crc_ff        <= crc_in;
         pkt_hdr_ff    <= pkt_hdr_in;
         pkt_cmd_ff    <= pkt_cmd_in;
         crc_lo_ff     <= crc_lo_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      crc_hi_ff   <= crc_hi_in;
      rep_hdr_ff  <= rep_hdr_in;
      crc_req_ff  <= crc_req_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_kind  = rsp_data_ff.kind;
   assign rsp.payload_byte = rsp_data_ff.payload_byte;
   assign rsp.verdict      = rsp_data_ff.verdict;
   assign rsp.message_type = rsp_data_ff.message_type;
   assign rsp.command_code = rsp_data_ff.command_code;
   assign rsp.data_count   = rsp_data_ff.data_count;
   assign rsp.last_result  = rsp_last_ff;

   // checks
   `RPR_ASSERT_HOLDS(a_idle_no_pending, clock, reset, state_ff == ST_IDLE, !pend_valid_ff, "held result left over after report end")
   `RPR_ASSERT_HOLDS(a_open_incomplete, clock, reset, state_ff == ST_IDLE && open_ff, taken_ff < exp_len_ff, "open packet already complete")
   `RPR_ASSERT_HOLDS(a_walk_index, clock, reset, state_ff == ST_WALK, idx_ff <= len_ff && idx_ff != '0, "walk index outside the report")
   `RPR_ASSERT_NEXT(a_flush_exit, clock, reset, state_ff == ST_FLUSH && (!pend_valid_ff || out_free), state_ff == ST_IDLE && !pend_valid_ff, "flush did not complete")

endmodule

[bench/tb_report_packet_reassembler_crc_check.sv]
`timescale 1ns / 1ps
// self-checking bench for the report packet reassembler with crc-16/buypass check
// depends on rpr_pkg, rpr_req_if, rpr_rsp_if and report_packet_reassembler_crc_check
// directed report sequences, then random well-formed and broken packets in four idle phases

module tb_report_packet_reassembler_crc_check;
   import rpr_pkg::*;

   localparam int RANDOM_ITEMS = 180;
   localparam int RESULT_CAP   = 20;      // results kept per input byte
   localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
   localparam int TAIL_CYCLES  = 64;      // quiet time after the last result
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum int {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_mode_t;

   // one pending request transaction plus its pacing controls
   typedef struct {
      logic [7:0] data;
      logic       first;
      logic       last;
      idle_mode_t mode;
      bit         drain;     // wait until every expected result has arrived
      bit         hold;      // ask the receiver for a long hold-off
   } pending_item_t;

   typedef struct packed {
      result_type res;
      logic       last;
   } rsp_item_t;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   // request side, driven at the rising edge
   logic       req_valid = 1'b0;
   logic [7:0] req_byte  = 8'h00;
   logic       req_first = 1'b0;
   logic       req_last  = 1'b0;
   logic       rsp_ready = 1'b0;

   rpr_req_if req_bus();
   rpr_rsp_if rsp_bus();

   assign req_bus.valid        = req_valid;
   assign req_bus.rx_byte      = req_byte;
   assign req_bus.report_first = req_first;
   assign req_bus.report_last  = req_last;
   assign rsp_bus.ready        = rsp_ready;

   report_packet_reassembler_crc_check dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // ------------------------------------------------------------------
   // predictor state: report buffer and the open packet
   // ------------------------------------------------------------------
   logic [7:0]  rb_store [REPORT_BYTES];
   int          rb_fill   = 0;
   bit          pk_open   = 1'b0;
   logic [9:0]  pk_len    = '0;
   logic [9:0]  pk_taken  = '0;
   logic [1:0]  pk_ctr    = '0;
   logic [15:0] pk_crc    = '0;
   logic [7:0]  pk_hdr    = '0;
   logic [7:0]  pk_cmd    = '0;
   logic [7:0]  pk_crc_lo = '0;

   rsp_item_t   step_results [$];     // results caused by the byte being predicted
   rsp_item_t   expected_results [$];
   pending_item_t pending [$];
   pending_item_t next_item;
   rsp_item_t   want_rsp;

   // bench bookkeeping
   int         pushed_count   = 0;
   int         items_accepted = 0;
   int         results_due    = 0;
   int         results_seen   = 0;
   int         hold_asks      = 0;
   int         hold_done      = 0;
   int         hold_left      = 0;
   int         fail_count     = 0;
   int         cycle_count    = 0;
   int         data_seen      = 0;
   int         verdict_seen [4] = '{0, 0, 0, 0};
   bit         cur_hold       = 1'b0;
   idle_mode_t mode_now       = IDLE_NONE;
   idle_mode_t gen_mode       = IDLE_NONE;
   bit         gen_drain      = 1'b0;
   bit         gen_hold       = 1'b0;

   // crc-16/buypass, one input bit at a time
   function automatic logic [15:0] buypass_step(input logic [15:0] c, input logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ d[i];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   // packet bytes that precede the crc trailer
   function automatic int pkt_data_end();
      if (pk_hdr[CRC_FLAG_BIT] && pk_len >= CRC_TRAILER) begin
         return int'(pk_len) - 2;
      end
      return int'(pk_len);
   endfunction

   function void add_result(input kind_type k, input logic [7:0] d, input verdict_type v,
                            input int t, input int c, input int n);
      rsp_item_t e;
      if (step_results.size() >= RESULT_CAP) begin
         return;
      end
      e.res.kind         = k;
      e.res.payload_byte = d;
      e.res.verdict      = v;
      e.res.message_type = t[1:0];
      e.res.command_code = c[7:0];
      e.res.data_count   = n[9:0];
      e.last             = 1'b0;
      step_results.push_back(e);
   endfunction

   // dropped packet: status carries the data bytes already sent out
   function void drop_packet();
      int upto;
      int cnt;
      upto = (int'(pk_taken) < pkt_data_end()) ? int'(pk_taken) : pkt_data_end();
      cnt  = (upto >= 3) ? upto - 3 : 0;
      add_result(KIND_STATUS, 8'h00, VERDICT_ABORT, pk_hdr[6:5], pk_cmd, cnt);
      pk_open  = 1'b0;
      pk_taken = '0;
   endfunction

   // expected results of one accepted request transaction
   task predict_report_byte(input logic [7:0] b, input logic first, input logic last);
      int         n;
      int         p;
      logic [7:0] hb;
      logic [7:0] cur;
      logic [7:0] crc_hi;
      bit         handle;
      step_results.delete();
      crc_hi = 8'h00;
      if (first) begin
         rb_fill = 0;
      end
      if (rb_fill < REPORT_BYTES) begin
         rb_store[rb_fill] = b;
         rb_fill++;
      end else begin
         rb_fill = REPORT_BYTES + 1;       // overflowed report, dropped at its end
      end
      if (last) begin
         n       = rb_fill;
         rb_fill = 0;
         if (n <= REPORT_BYTES && n != 0) begin
            hb     = rb_store[0];
            handle = 1'b1;
            if (hb[START_BIT]) begin
               // a new start closes whatever was open
               if (pk_open) begin
                  drop_packet();
               end
               pk_open  = 1'b0;
               pk_taken = '0;
               pk_len   = '0;
               pk_crc   = '0;
               if (n < MIN_START_RPT) begin
                  handle = 1'b0;
               end else begin
                  pk_len = {rb_store[1][1:0], rb_store[2]};
                  if (rb_store[1][CRC_FLAG_BIT] && pk_len < MIN_CRC_LEN) begin
                     handle = 1'b0;
                  end
               end
            end else if (!pk_open) begin
               handle = 1'b0;
            end else if (pk_ctr != hb[1:0]) begin
               // counter mismatch, expected counter stays as it was
               drop_packet();
               handle = 1'b0;
            end
            if (handle) begin
               pk_ctr = hb[1:0] + 2'd1;
               for (int i = 1; i < n && pk_taken < pk_len; i++) begin
                  p   = int'(pk_taken);
                  cur = rb_store[i];
                  if (p == 0) begin
                     pk_hdr = cur;
                  end
                  if (p == 2) begin
                     pk_cmd = cur;
                  end
                  if (pk_hdr[CRC_FLAG_BIT]) begin
                     if (p + 2 < int'(pk_len)) begin
                        pk_crc = buypass_step(pk_crc, cur);
                     end else if (p + 2 == int'(pk_len)) begin
                        pk_crc_lo = cur;
                     end else begin
                        crc_hi = cur;
                     end
                  end
                  if (p >= 3 && p < pkt_data_end()) begin
                     add_result(KIND_DATA, cur, VERDICT_OK, 0, 0, 0);
                  end
                  pk_taken = p + 1;
               end
               if (pk_taken >= pk_len) begin
                  if (pk_len < MIN_PKT_LEN) begin
                     add_result(KIND_STATUS, 8'h00, VERDICT_SHORT, 0, 0, 0);
                  end else begin
                     add_result(KIND_STATUS, 8'h00,
                                (pk_hdr[CRC_FLAG_BIT] && pk_crc != {crc_hi, pk_crc_lo}) ?
                                   VERDICT_CRC_BAD : VERDICT_OK,
                                pk_hdr[6:5], pk_cmd, pkt_data_end() - 3);
                  end
                  pk_open  = 1'b0;
                  pk_taken = '0;
               end else begin
                  pk_open = 1'b1;
               end
            end
         end
      end
      if (step_results.size() != 0) begin
         step_results[$].last = 1'b1;
      end
      foreach (step_results[i]) begin
         expected_results.push_back(step_results[i]);
      end
      results_due += step_results.size();
   endtask

   // ------------------------------------------------------------------
   // stimulus building
   // ------------------------------------------------------------------
   task push_byte(input logic [7:0] d, input logic f, input logic l);
      pending_item_t it;
      it.data  = d;
      it.first = f;
      it.last  = l;
      it.mode  = gen_mode;
      it.drain = gen_drain;
      it.hold  = gen_hold;
      gen_drain = 1'b0;
      gen_hold  = 1'b0;
      pending.push_back(it);
      pushed_count++;
   endtask

   // well-formed packet split over reports with running counters;
   // when whole is clear the packet may stop partway
   task gen_packet(input bit whole);
      logic [7:0]  pkt [$];
      logic [9:0]  plen;
      logic [15:0] c;
      logic [7:0]  hb;
      logic [7:0]  b;
      logic [1:0]  ctr;
      int          n_data;
      int          at;
      int          chunk;
      bit          crc_on;
      bit          opening;
      pkt.delete();
      crc_on = $urandom_range(1);
      n_data = ($urandom_range(7) == 0) ? $urandom_range(60, 13) : $urandom_range(12);
      plen   = 3 + n_data + (crc_on ? 2 : 0);
      b      = $urandom_range(255);
      b[CRC_FLAG_BIT] = crc_on;
      b[1:0] = plen[9:8];
      pkt.push_back(b);
      pkt.push_back(plen[7:0]);
      pkt.push_back(8'($urandom_range(255)));
      repeat (n_data) pkt.push_back(8'($urandom_range(255)));
      if (crc_on) begin
         c = '0;
         foreach (pkt[i]) begin
            c = buypass_step(c, pkt[i]);
         end
         // now and then a corrupted trailer
         if ($urandom_range(6) == 0) begin
            c = c ^ (16'h0001 << $urandom_range(15));
         end
         pkt.push_back(c[7:0]);
         pkt.push_back(c[15:8]);
      end
      at      = 0;
      opening = 1'b1;
      ctr     = 2'd0;
      while (at < pkt.size()) begin
         hb = $urandom_range(255);
         if (opening) begin
            hb[START_BIT] = 1'b1;
            ctr = hb[1:0] + 2'd1;
         end else begin
            hb[START_BIT] = 1'b0;
            hb[1:0] = ctr;
            ctr = ctr + 2'd1;
         end
         chunk = $urandom_range(REPORT_BYTES - 1, opening ? 3 : 1);
         // mostly trim the last report, sometimes leave surplus bytes
         if (chunk > pkt.size() - at && $urandom_range(4) != 0) begin
            chunk = pkt.size() - at;
         end
         push_byte(hb, 1'b1, 1'b0);
         for (int i = 0; i < chunk; i++) begin
            push_byte((at + i < pkt.size()) ? pkt[at + i] : 8'($urandom_range(255)),
                      1'b0, i == chunk - 1);
         end
         at += chunk;
         opening = 1'b0;
         if (!whole && $urandom_range(2) == 0) begin
            break;
         end
      end
   endtask

   // pacing: is this side active this cycle
   function automatic bit roll_active(input idle_mode_t m, input bit is_rx);
      int idle_pct;
      idle_pct = 0;
      if (m == IDLE_BOTH) begin
         idle_pct = 28;
      end else if (is_rx ? (m == IDLE_RECV) : (m == IDLE_SEND)) begin
         idle_pct = 73;
      end
      return $urandom_range(99) >= idle_pct;
   endfunction

   function void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // ------------------------------------------------------------------
   // driver: one request transaction at a time from the pending queue
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_bus.ready) begin
            predict_report_byte(req_byte, req_first, req_last);
            items_accepted <= items_accepted + 1;
            if (cur_hold) begin
               hold_asks <= hold_asks + 1;
            end
         end
         // a held offer stays put until it is taken
         if (!req_valid || req_bus.ready) begin
            if (pending.size() != 0 && (!pending[0].drain || results_seen == results_due)
                && roll_active(pending[0].mode, 1'b0)) begin
               next_item = pending.pop_front();
               req_valid <= 1'b1;
               req_byte  <= next_item.data;
               req_first <= next_item.first;
               req_last  <= next_item.last;
               cur_hold  <= next_item.hold;
               mode_now  <= next_item.mode;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: check each response transaction, pace ready
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual kind %0d byte %0d",
                        $time, rsp_bus.result_kind, rsp_bus.payload_byte);
               fail_count++;
            end else begin
               want_rsp = expected_results.pop_front();
               check_field("result_kind", want_rsp.res.kind, rsp_bus.result_kind);
               check_field("payload_byte", want_rsp.res.payload_byte, rsp_bus.payload_byte);
               check_field("verdict", want_rsp.res.verdict, rsp_bus.verdict);
               check_field("message_type", want_rsp.res.message_type, rsp_bus.message_type);
               check_field("command_code", want_rsp.res.command_code, rsp_bus.command_code);
               check_field("data_count", want_rsp.res.data_count, rsp_bus.data_count);
               check_field("last_result", want_rsp.last, rsp_bus.last_result);
               results_seen <= results_seen + 1;
               if (want_rsp.res.kind == KIND_DATA) begin
                  data_seen++;
               end else begin
                  verdict_seen[want_rsp.res.verdict]++;
               end
            end
         end
         // long hold-off so the block backs up into its input
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (hold_done != hold_asks) begin
            rsp_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_done + 1;
         end else begin
            rsp_ready <= roll_active(mode_now, 1'b1);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, results_due - results_seen);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int         pick;
      int         n;
      int         directed_count;
      int         random_count;
      int         phase;
      bit         hold_planned;
      logic [7:0] hb;
      hold_planned = 1'b0;

      // lone continuation with no packet open: ignored
      push_byte(8'h7F, 1'b1, 1'b1);
      // short start report: nothing to abort, ignored
      push_byte(8'hFF, 1'b1, 1'b0);
      push_byte(8'h00, 1'b0, 1'b1);
      // crc flag with length four: ignored
      push_byte(8'h80, 1'b1, 1'b0);
      push_byte(8'h10, 1'b0, 1'b0);
      push_byte(8'h04, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b1);
      // length two: too short status, trailing byte is surplus
      push_byte(8'h80, 1'b1, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h02, 1'b0, 1'b0);
      push_byte(8'hAA, 1'b0, 1'b1);
      // type 3 packet left open, then a wrong counter aborts it
      push_byte(8'h83, 1'b1, 1'b0);
      push_byte(8'h60, 1'b0, 1'b0);
      push_byte(8'h05, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b1);
      push_byte(8'h02, 1'b1, 1'b1);
      // stray byte without header mark, then a header restarts the report
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h80, 1'b1, 1'b0);
      push_byte(8'h10, 1'b0, 1'b0);
      push_byte(8'h07, 1'b0, 1'b0);
      push_byte(8'h5A, 1'b0, 1'b0);
      push_byte(8'hC3, 1'b0, 1'b1);
      // new start while open aborts the crc packet, opens one of maximum length
      push_byte(8'hFC, 1'b1, 1'b0);
      push_byte(8'h03, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'h01, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b1);
      directed_count = pushed_count;

      // random part: mostly well-formed packets, the rest broken or noise
      while (pushed_count - directed_count < RANDOM_ITEMS) begin
         random_count = pushed_count - directed_count;
         phase = random_count * 4 / RANDOM_ITEMS;
         if (idle_mode_t'(phase) != gen_mode) begin
            gen_mode  = idle_mode_t'(phase);
            gen_drain = 1'b1;
         end
         if (!hold_planned && random_count >= 20) begin
            gen_hold     = 1'b1;
            hold_planned = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 50) begin
            gen_packet(1'b1);
         end else if (pick < 62) begin
            gen_packet(1'b0);
         end else if (pick < 68) begin
            // unfinished report cut off by a header mark
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++) begin
               push_byte(8'($urandom_range(255)), i == 0, 1'b0);
            end
            gen_packet(1'b1);
         end else if (pick < 74) begin
            // oversized report, dropped whole
            n = $urandom_range(REPORT_BYTES + 4, REPORT_BYTES + 1);
            for (int i = 0; i < n; i++) begin
               push_byte(8'($urandom_range(255)), i == 0, i == n - 1);
            end
         end else if (pick < 80) begin
            // start report too short to hold a packet header
            n  = $urandom_range(3, 1);
            hb = $urandom_range(255);
            hb[START_BIT] = 1'b1;
            push_byte(hb, 1'b1, n == 1);
            for (int i = 1; i < n; i++) begin
               push_byte(8'($urandom_range(255)), 1'b0, i == n - 1);
            end
         end else if (pick < 86) begin
            // crc flag with a length that cannot hold the trailer
            hb = $urandom_range(255);
            hb[START_BIT] = 1'b1;
            push_byte(hb, 1'b1, 1'b0);
            hb = $urandom_range(255);
            hb[CRC_FLAG_BIT] = 1'b1;
            hb[1:0] = 2'b00;
            push_byte(hb, 1'b0, 1'b0);
            n = $urandom_range(3);
            push_byte(8'($urandom_range(4)), 1'b0, n == 0);
            for (int i = 0; i < n; i++) begin
               push_byte(8'($urandom_range(255)), 1'b0, i == n - 1);
            end
         end else if (pick < 93) begin
            // continuation with a random counter
            n  = $urandom_range(5, 1);
            hb = $urandom_range(255);
            hb[START_BIT] = 1'b0;
            push_byte(hb, 1'b1, n == 1);
            for (int i = 1; i < n; i++) begin
               push_byte(8'($urandom_range(255)), 1'b0, i == n - 1);
            end
         end else begin
            // noise with random marks
            n = $urandom_range(4, 1);
            repeat (n) push_byte(8'($urandom_range(255)), $urandom_range(1), $urandom_range(1));
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted != pushed_count) @(posedge clock);
      while (results_seen != results_due) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d report bytes over four idle phases with a long receiver hold-off",
               pushed_count);
      $display("checked %0d results: %0d data, status ok %0d crc bad %0d short %0d aborted %0d",
               results_seen, data_seen, verdict_seen[VERDICT_OK], verdict_seen[VERDICT_CRC_BAD],
               verdict_seen[VERDICT_SHORT], verdict_seen[VERDICT_ABORT]);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
